// ===== sv/pfwq_pkg.sv =====
`default_nettype none

package pfwq_pkg;

    // Field widths of one work item and one result
    localparam int CMD_W    = 1;
    localparam int DOMAIN_W = 2;
    localparam int PRIO_W   = 8;
    localparam int KIND_W   = 32;
    localparam int TICK_W   = 64;
    localparam int PEND_W   = 5;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SUBMIT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 1'b1;

    // One stored entry, domain in the lowest bits
    typedef struct packed {
        logic [TICK_W-1:0]   tick;
        logic [KIND_W-1:0]   kind;
        logic [PRIO_W-1:0]   prio;
        logic [DOMAIN_W-1:0] domain;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((CMD_W + ENTRY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((1 + ENTRY_W + PEND_W + PRIO_W + 7) / 8) * 8;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic push;
        logic idx_clear;
        logic scan_rd;
        logic shift_init;
        logic shift_rd;
        logic take_done;
        logic load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_take;
        logic empty;
        logic scan_last;
        logic shift_none;
        logic shift_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/pfwq_ram.sv =====
`default_nettype none

module pfwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, read one entry with registered output
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/pfwq_ctrl.sv =====
`default_nettype none

module pfwq_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire pfwq_pkg::status_t status,
    output pfwq_pkg::cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_DECODE     = 4'd1;
    localparam logic [3:0] ST_SCAN       = 4'd2;
    localparam logic [3:0] ST_SCAN_END   = 4'd3;
    localparam logic [3:0] ST_SHIFT_INIT = 4'd4;
    localparam logic [3:0] ST_SHIFT      = 4'd5;
    localparam logic [3:0] ST_SHIFT_END  = 4'd6;
    localparam logic [3:0] ST_TAKE_END   = 4'd7;
    localparam logic [3:0] ST_DONE       = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Sequence one command through push, or scan and compaction, then result
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.idx_clear = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!status.is_take) begin
                    cmd.push   = 1'b1;
                    state_next = ST_DONE;
                end else if (status.empty) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                state_next = ST_SHIFT_INIT;
            end
            ST_SHIFT_INIT: begin
                cmd.shift_init = 1'b1;
                if (status.shift_none) begin
                    state_next = ST_TAKE_END;
                end else begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                cmd.shift_rd = 1'b1;
                if (status.shift_last) begin
                    state_next = ST_SHIFT_END;
                end
            end
            ST_SHIFT_END: begin
                state_next = ST_TAKE_END;
            end
            ST_TAKE_END: begin
                cmd.take_done = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pfwq_dpath.sv =====
`default_nettype none

module pfwq_dpath #(
    parameter int QUEUE_DEPTH = pfwq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [pfwq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [pfwq_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire pfwq_pkg::cmd_t                   cmd,
    output pfwq_pkg::status_t                     status
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = pfwq_pkg::ENTRY_W;
    localparam int PW = pfwq_pkg::PRIO_W;

    logic [pfwq_pkg::CMD_W-1:0] in_cmd_reg,   in_cmd_next;
    pfwq_pkg::entry_t           in_entry_reg, in_entry_next;
    logic [CW-1:0]              count_reg,    count_next;
    logic [PW-1:0]              top_reg,      top_next;
    logic [CW-1:0]              idx_reg,      idx_next;
    logic                       rd_v_reg,     rd_v_next;
    logic                       rd_first_reg, rd_first_next;
    logic [CW-1:0]              rd_idx_reg,   rd_idx_next;
    logic                       sh_v_reg,     sh_v_next;
    logic [CW-1:0]              sh_idx_reg,   sh_idx_next;
    pfwq_pkg::entry_t           best_reg,     best_next;
    logic [CW-1:0]              best_idx_reg, best_idx_next;
    logic [PW-1:0]              other_reg,    other_next;
    logic                       res_ok_reg,   res_ok_next;
    logic                       res_take_reg, res_take_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [pfwq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic             full;
    logic [CW-1:0]    last_idx;
    logic [CW-1:0]    sh_dst;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [EW-1:0]    wr_data;
    logic [EW-1:0]    rd_raw;
    pfwq_pkg::entry_t rd_entry;
    pfwq_pkg::entry_t res_entry;
    logic             better;
    logic             out_free;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign last_idx = count_reg - CW'(1);
    assign sh_dst   = sh_idx_reg - CW'(1);
    assign rd_entry = pfwq_pkg::entry_t'(rd_raw);
    assign out_free = !m_tvalid_reg || m_tready;

    // Higher priority wins, then the older tick; exact ties keep the earlier slot
    assign better = (rd_entry.prio > best_reg.prio) ||
                    ((rd_entry.prio == best_reg.prio) && (rd_entry.tick < best_reg.tick));

    // Entry storage: push at the tail, compaction moves one entry down per cycle
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = EW'(in_entry_reg);
        if (cmd.push && !full) begin
            wr_en = 1'b1;
        end else if (sh_v_reg) begin
            wr_en   = 1'b1;
            wr_addr = sh_dst[AW-1:0];
            wr_data = rd_raw;
        end
    end

    pfwq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.scan_rd || cmd.shift_rd),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_raw)
    );

    assign status.is_take    = (in_cmd_reg == pfwq_pkg::CMD_TAKE);
    assign status.empty      = (count_reg == '0);
    assign status.scan_last  = (idx_reg == last_idx);
    assign status.shift_none = ((best_idx_reg + CW'(1)) == count_reg);
    assign status.shift_last = (idx_reg == last_idx);
    assign status.out_free   = out_free;

    assign res_entry = res_take_reg ? best_reg : '0;

    // Next-state logic of the datapath registers
    always_comb begin
        in_cmd_next   = in_cmd_reg;
        in_entry_next = in_entry_reg;
        count_next    = count_reg;
        top_next      = top_reg;
        idx_next      = idx_reg;
        rd_v_next     = cmd.scan_rd;
        rd_first_next = cmd.scan_rd && (idx_reg == '0);
        rd_idx_next   = idx_reg;
        sh_v_next     = cmd.shift_rd;
        sh_idx_next   = idx_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        other_next    = other_reg;
        res_ok_next   = res_ok_reg;
        res_take_next = res_take_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        // Capture the accepted transfer
        if (cmd.load_in) begin
            in_cmd_next   = s_tdata[pfwq_pkg::CMD_W-1:0];
            in_entry_next = pfwq_pkg::entry_t'(s_tdata[pfwq_pkg::CMD_W +: EW]);
            res_ok_next   = 1'b0;
            res_take_next = 1'b0;
        end

        // Submit: append if there is room
        if (cmd.push && !full) begin
            count_next  = count_reg + CW'(1);
            res_ok_next = 1'b1;
            if (in_entry_reg.prio > top_reg) begin
                top_next = in_entry_reg.prio;
            end
        end

        // Advance the slot counter
        if (cmd.idx_clear) begin
            idx_next = '0;
        end else if (cmd.shift_init) begin
            idx_next = best_idx_reg + CW'(1);
        end else if (cmd.scan_rd || cmd.shift_rd) begin
            idx_next = idx_reg + CW'(1);
        end

        // Track the best entry and the highest priority of all others
        if (rd_v_reg) begin
            if (rd_first_reg) begin
                best_next     = rd_entry;
                best_idx_next = rd_idx_reg;
                other_next    = '0;
            end else if (better) begin
                best_next     = rd_entry;
                best_idx_next = rd_idx_reg;
                if (best_reg.prio > other_reg) begin
                    other_next = best_reg.prio;
                end
            end else if (rd_entry.prio > other_reg) begin
                other_next = rd_entry.prio;
            end
        end

        // Finish a take
        if (cmd.take_done) begin
            count_next    = count_reg - CW'(1);
            top_next      = other_reg;
            res_ok_next   = 1'b1;
            res_take_next = 1'b1;
        end

        // Output register
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {top_reg, pfwq_pkg::PEND_W'(count_reg), EW'(res_entry), res_ok_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            top_reg      <= '0;
            rd_v_reg     <= 1'b0;
            sh_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            top_reg      <= top_next;
            rd_v_reg     <= rd_v_next;
            sh_v_reg     <= sh_v_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_cmd_reg   <= in_cmd_next;
        in_entry_reg <= in_entry_next;
        idx_reg      <= idx_next;
        rd_first_reg <= rd_first_next;
        rd_idx_reg   <= rd_idx_next;
        sh_idx_reg   <= sh_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        other_reg    <= other_next;
        res_ok_reg   <= res_ok_next;
        res_take_reg <= res_take_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== sv/priority_fifo_work_queue_top.sv =====
`default_nettype none

// Bounded work queue of QUEUE_DEPTH entries. Each input transfer is a submit or a
// take-next command and yields exactly one result transfer. A submit appends the
// item at the tail (refused with ok = 0 when full). A take-next reads every held
// entry once through the read port of the entry memory to pick the highest
// priority (oldest tick on equal priority, lowest slot on an exact tie), then
// moves each later entry down one slot, one per cycle. One command is in work at
// a time; the result register lets the next command be accepted while the
// previous result waits. Each result also carries the number of entries held and
// the highest priority still held (0 when empty).
module priority_fifo_work_queue_top #(
    parameter int QUEUE_DEPTH = pfwq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // command[0], job_domain[2:1], job_priority[10:3], job_kind[42:11],
    // job_tick[106:43], zero pad[111:107]
    input  wire logic [pfwq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // ok[0], out_domain[2:1], out_priority[10:3], out_kind[42:11],
    // out_tick[106:43], pending_after[111:107], top_pending_priority[119:112]
    output logic      [pfwq_pkg::M_TDATA_W-1:0] m_tdata
);

    pfwq_pkg::cmd_t    cmd;
    pfwq_pkg::status_t status;

    pfwq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfwq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

// ===== tb/priority_fifo_work_queue_top_tb.sv =====
`default_nettype none

module priority_fifo_work_queue_top_tb;

    import pfwq_pkg::*;

    localparam int QDEPTH       = DEFAULT_QUEUE_DEPTH;
    localparam int S_PAD_W      = S_TDATA_W - CMD_W - ENTRY_W;
    localparam int CLK_HALF     = 10;
    localparam int SETTLE_CYCLES = 4 * QDEPTH + 20;
    localparam int RUN_LIMIT    = 1_000_000;

    // Input transfer layout, command in the lowest bit
    typedef struct packed {
        logic [S_PAD_W-1:0] pad;
        entry_t             item;
        logic [CMD_W-1:0]   cmd;
    } command_word_t;

    // Result transfer layout, ok in the lowest bit
    typedef struct packed {
        logic [PRIO_W-1:0] top_prio;
        logic [PEND_W-1:0] pending;
        entry_t            item;
        logic              ok;
    } queue_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the queue contents
    entry_t        shadow_slots [QDEPTH];
    int            shadow_held = 0;

    queue_result_t expected_results [$];
    int            mismatch_count   = 0;

    // Traffic shaping knobs shared by stimulus and result sink
    bit            tx_gaps_on       = 1'b1;
    bit            rx_gaps_on       = 1'b1;
    int            rx_hold_cycles   = 0;
    logic [63:0]   tick_clock       = 64'd100;

    priority_fifo_work_queue_top #(
        .QUEUE_DEPTH(QDEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Apply one command to the shadow queue and return the result it yields
    function automatic queue_result_t predict_queue_step(logic [CMD_W-1:0] cmd, entry_t item);
        queue_result_t res;
        int            best;
        res = '0;
        if (cmd == CMD_SUBMIT) begin
            if (shadow_held < QDEPTH) begin
                shadow_slots[shadow_held] = item;
                shadow_held++;
                res.ok = 1'b1;
            end
        end else if (shadow_held > 0) begin
            best = 0;
            // Strictly better wins, so the earlier slot keeps an exact tie
            for (int i = 1; i < shadow_held; i++) begin
                if (shadow_slots[i].prio > shadow_slots[best].prio) begin
                    best = i;
                end else if (shadow_slots[i].prio == shadow_slots[best].prio &&
                             shadow_slots[i].tick < shadow_slots[best].tick) begin
                    best = i;
                end
            end
            res.item = shadow_slots[best];
            // Compact the later entries down one slot
            for (int i = best + 1; i < shadow_held; i++) begin
                shadow_slots[i-1] = shadow_slots[i];
            end
            shadow_held--;
            res.ok = 1'b1;
        end
        res.pending = shadow_held[PEND_W-1:0];
        for (int i = 0; i < shadow_held; i++) begin
            if (shadow_slots[i].prio > res.top_prio) begin
                res.top_prio = shadow_slots[i].prio;
            end
        end
        return res;
    endfunction

    // Draw a work item; small priority set and slowly moving ticks force ties
    function automatic entry_t random_job();
        entry_t job;
        job.domain = DOMAIN_W'($urandom_range(0, 3));
        job.kind   = $urandom;
        case ($urandom_range(0, 3))
            0:       job.prio = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
            1, 2:    job.prio = PRIO_W'($urandom_range(1, 4));
            default: job.prio = PRIO_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 5))
            0: job.tick = {$urandom, $urandom};
            1: job.tick = tick_clock - 64'($urandom_range(0, 3));
            default: begin
                tick_clock = tick_clock + 64'($urandom_range(0, 2));
                job.tick   = tick_clock;
            end
        endcase
        return job;
    endfunction

    function automatic entry_t make_job(logic [DOMAIN_W-1:0] domain, logic [PRIO_W-1:0] prio,
                                        logic [KIND_W-1:0] kind, logic [TICK_W-1:0] tick);
        entry_t job;
        job.domain = domain;
        job.prio   = prio;
        job.kind   = kind;
        job.tick   = tick;
        return job;
    endfunction

    // Offer one command and hold it until the transfer, then log its result
    task automatic send_command(logic [CMD_W-1:0] cmd, entry_t item);
        command_word_t word;
        int            gap;
        gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word      = '0;
        word.cmd  = cmd;
        word.item = item;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_queue_step(cmd, item));
    endtask

    // Stop offering and wait for every pending result
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            mismatch_count++;
        end
    endtask

    // Result sink: random stalls, optional long hold-off, compare in order
    initial begin : result_sink
        queue_result_t got;
        queue_result_t exp;
        int            stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            stall = rx_gaps_on ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = m_tdata;
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: 0x%0h", m_tdata);
                mismatch_count++;
            end else begin
                exp = expected_results.pop_front();
                check_field("ok", 64'(exp.ok), 64'(got.ok));
                check_field("out_domain", 64'(exp.item.domain), 64'(got.item.domain));
                check_field("out_priority", 64'(exp.item.prio), 64'(got.item.prio));
                check_field("out_kind", 64'(exp.item.kind), 64'(got.item.kind));
                check_field("out_tick", exp.item.tick, got.item.tick);
                check_field("pending_after", 64'(exp.pending), 64'(got.pending));
                check_field("top_pending_priority", 64'(exp.top_prio), 64'(got.top_prio));
            end
        end
    end

    // Take on an empty queue; junk in the item fields must be ignored
    task automatic test_take_on_empty();
        send_command(CMD_TAKE, make_job(2'd3, 8'hA5, 32'hDEAD_BEEF, 64'hFFFF_0000_FFFF_0000));
    endtask

    // Fill the queue with field extremes, equal priorities and exact ties
    task automatic test_fill_with_extremes();
        entry_t job;
        send_command(CMD_SUBMIT, make_job(2'd3, 8'd255, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_command(CMD_SUBMIT, make_job(2'd0, 8'd0, 32'd0, 64'd0));
        send_command(CMD_SUBMIT, make_job(2'd2, 8'd255, 32'd0, 64'd0));
        send_command(CMD_SUBMIT, make_job(2'd1, 8'd7, 32'd1234, 64'd5));
        send_command(CMD_SUBMIT, make_job(2'd1, 8'd7, 32'd5678, 64'd5));
        send_command(CMD_SUBMIT, make_job(2'd2, 8'd7, 32'd9, 64'd3));
        for (int i = shadow_held; i < QDEPTH; i++) begin
            job      = random_job();
            job.prio = PRIO_W'($urandom_range(0, 100));
            send_command(CMD_SUBMIT, job);
        end
    endtask

    // Submit while full is refused
    task automatic test_submit_when_full();
        send_command(CMD_SUBMIT, make_job(2'd1, 8'd254, 32'h5555_AAAA, 64'd1));
    endtask

    // Takes pull highest priority, then oldest tick, then lowest slot
    task automatic test_take_order();
        repeat (6) send_command(CMD_TAKE, random_job());
        wait_for_results();
    endtask

    // Receiver holds off while the sender streams back to back
    task automatic test_backpressure();
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = 300;
        repeat (18) send_command(CMD_SUBMIT, random_job());
        repeat (4) send_command(CMD_TAKE, random_job());
        tx_gaps_on = 1'b1;
        wait_for_results();
    endtask

    // Bursts with a varying submit mix so the queue swings between empty and full
    task automatic test_random_traffic(int n_items);
        int sent;
        int burst;
        int submit_pct;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(10, 60);
            case ($urandom_range(0, 4))
                0:       submit_pct = 10;
                1:       submit_pct = 30;
                2:       submit_pct = 50;
                3:       submit_pct = 70;
                default: submit_pct = 90;
            endcase
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                if ($urandom_range(1, 100) <= submit_pct) begin
                    send_command(CMD_SUBMIT, random_job());
                end else begin
                    send_command(CMD_TAKE, random_job());
                end
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                wait_for_results();
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin : test_sequence
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_take_on_empty();
        test_fill_with_extremes();
        test_submit_when_full();
        test_take_order();
        test_backpressure();
        test_random_traffic(920);

        // Drain, then let any stray result show up
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(2 * CLK_HALF * RUN_LIMIT);
        $error("timeout with %0d results outstanding", expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
